[rtl/core/pps_pkg.sv]
// Shared constants and types for the perspective projection pipeline.
package pps_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_ROWS   = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_X_ROW_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_ROW_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ROW_LO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ROW_HI   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_ROW_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_ROW_HI   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_HEIGHT = 3'd7;

  // Clip coordinate width: three 64-bit products summed, floored, plus offset.
  localparam int CW    = 67 - FRAC_BITS;
  // Magnitude of a clip value and of a positive W.
  localparam int MW    = CW;
  localparam int WW    = CW - 1;
  // Half viewport size in fixed point.
  localparam int HW    = SIZE_W + FRAC_BITS - 1;
  // Dividend width and split point of the dividend multiply.
  localparam int NW    = HW + MW;
  localparam int ML    = MW / 2;
  // Quotient bits kept; anything at or above 2^QB saturates the output anyway.
  localparam int QB    = (FRAC_BITS + 14 > 33) ? FRAC_BITS + 14 : 33;
  localparam int XW    = CW + QB;
  localparam int RW    = QB + 2;
  localparam int W_MIN = ((1 << FRAC_BITS) + 5) / 10;

  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
  } meta_t;

endpackage

[rtl/core/pps_if.sv]
// Input point channel and screen result channel.
interface pps_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pps_out_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;

  modport source (output valid, output visible, output screen_x, output screen_y, input ready);
  modport sink (input valid, input visible, input screen_x, input screen_y, output ready);
endinterface

[rtl/core/pps_div.sv]
// Pipelined restoring divider for both screen axes, one quotient bit per stage.
module pps_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  pps_pkg::meta_t           meta_i,
  input  logic [pps_pkg::NW-1:0]   nx_i,
  input  logic [pps_pkg::NW-1:0]   ny_i,
  input  logic [pps_pkg::WW-1:0]   w_i,
  output logic                     vld_o,
  output pps_pkg::meta_t           meta_o,
  output logic [pps_pkg::QB-1:0]   qx_o,
  output logic [pps_pkg::QB-1:0]   qy_o,
  output logic                     ovfx_o,
  output logic                     ovfy_o
);
  import pps_pkg::*;

  logic          vld_r  [QB+1];
  meta_t         meta_r [QB+1];
  logic [WW-1:0] w_r    [QB+1];
  logic [XW-1:0] rx_r   [QB+1];
  logic [XW-1:0] ry_r   [QB+1];
  logic [QB-1:0] qx_r   [QB+1];
  logic [QB-1:0] qy_r   [QB+1];
  logic          ox_r   [QB+1];
  logic          oy_r   [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  // The first stage flags quotients too large to represent.
  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= meta_i;
      w_r[0]    <= w_i;
      rx_r[0]   <= XW'(nx_i);
      ry_r[0]   <= XW'(ny_i);
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      ox_r[0]   <= XW'(nx_i) >= (XW'(w_i) << QB);
      oy_r[0]   <= XW'(ny_i) >= (XW'(w_i) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int BI = QB - k;
    logic [XW-1:0] dsh;
    logic          gex;
    logic          gey;

    assign dsh = XW'(w_r[k-1]) << BI;
    assign gex = rx_r[k-1] >= dsh;
    assign gey = ry_r[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[k] <= meta_r[k-1];
        w_r[k]    <= w_r[k-1];
        ox_r[k]   <= ox_r[k-1];
        oy_r[k]   <= oy_r[k-1];
        rx_r[k]   <= gex ? rx_r[k-1] - dsh : rx_r[k-1];
        ry_r[k]   <= gey ? ry_r[k-1] - dsh : ry_r[k-1];
        qx_r[k]   <= qx_r[k-1] | (QB'(gex) << BI);
        qy_r[k]   <= qy_r[k-1] | (QB'(gey) << BI);
      end
    end
  end

  assign vld_o  = vld_r[QB];
  assign meta_o = meta_r[QB];
  assign qx_o   = qx_r[QB];
  assign qy_o   = qy_r[QB];
  assign ovfx_o = ox_r[QB];
  assign ovfy_o = oy_r[QB];

endmodule

[rtl/core/perspective_project_to_screen.sv]
// Top level of the world-to-screen projection pipeline.
//
//   channel  | direction | payload
//   in_ch    | sink      | pos_x, pos_y, pos_z (signed Q16.16)
//   out_ch   | source    | visible, screen_x, screen_y (signed Q16.16)
//   cfg_*    | write     | cfg_idx selects one of eight registers, cfg_data
//
// One point is taken per cycle while the output register is not stalled; each
// result passes the front stages and the one-bit-per-stage divider chain
// before it reaches the output register.
// Reset is synchronous and clears the valid bits and all configuration registers.
// When the output register holds a result that is not taken, the whole pipeline
// freezes and in_ch.ready drops; nothing in flight is lost or repeated.
module perspective_project_to_screen (
  input  logic                            clk,
  input  logic                            rst_n,
  pps_in_if.sink                          in_ch,
  pps_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pps_pkg::*;

  logic [CFG_DATA_W-1:0] row_r [2*NUM_ROWS];
  logic [SIZE_W-1:0]     width_r;
  logic [SIZE_W-1:0]     height_r;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [63:0]   prod_r [NUM_ROWS][3];
  logic signed [65:0]   sum_r  [NUM_ROWS];
  logic signed [CW-1:0] clip_r [NUM_ROWS];

  meta_t               meta4_r, meta5_r, meta6_r;
  logic [MW-1:0]       magx_r, magy_r;
  logic [WW-1:0]       w4_r, w5_r, w6_r;
  logic [HW+ML-1:0]    plox_r, ploy_r;
  logic [HW+MW-ML-1:0] phix_r, phiy_r;
  logic [NW-1:0]       nx_r, ny_r;

  logic [HW-1:0] hx, hy;

  logic          dv_vld;
  meta_t         dv_meta;
  logic [QB-1:0] dv_qx, dv_qy;
  logic          dv_ovfx, dv_ovfy;

  logic               out_vld_r;
  logic               out_vis_r;
  logic signed [31:0] out_x_r;
  logic signed [31:0] out_y_r;

  logic signed [RW-1:0] tx, ty, resx, resy;
  logic signed [31:0]   sx_nxt, sy_nxt;

  function automatic logic signed [31:0] clamp32(input logic signed [RW-1:0] v);
    logic signed [31:0] r;
    if (v > $signed({{(RW-32){1'b0}}, 32'h7fff_ffff})) begin
      r = 32'sh7fff_ffff;
    end else if (v < $signed({{(RW-32){1'b1}}, 32'h8000_0000})) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [RW-1:0] ratio(input logic [QB-1:0] q, input logic ovf,
                                                 input logic neg);
    logic [QB:0] qs;
    qs = ovf ? {1'b1, {QB{1'b0}}} : {1'b0, q};
    return neg ? -$signed(RW'(qs)) : $signed(RW'(qs));
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2*NUM_ROWS; i++) begin
        row_r[i] <= '0;
      end
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_ROW_LO:   row_r[0] <= cfg_data;
        REG_X_ROW_HI:   row_r[1] <= cfg_data;
        REG_Y_ROW_LO:   row_r[2] <= cfg_data;
        REG_Y_ROW_HI:   row_r[3] <= cfg_data;
        REG_W_ROW_LO:   row_r[4] <= cfg_data;
        REG_W_ROW_HI:   row_r[5] <= cfg_data;
        REG_SCR_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_SCR_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  assign hx = {width_r, {(FRAC_BITS-1){1'b0}}};
  assign hy = {height_r, {(FRAC_BITS-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: nine products of matrix entries and coordinates.
      for (int r = 0; r < NUM_ROWS; r++) begin
        prod_r[r][0] <= $signed(row_r[2*r][31:0])    * in_ch.pos_x;
        prod_r[r][1] <= $signed(row_r[2*r][63:32])   * in_ch.pos_y;
        prod_r[r][2] <= $signed(row_r[2*r+1][31:0])  * in_ch.pos_z;
      end
      // Stage 2: exact row sums.
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum_r[r] <= 66'(prod_r[r][0]) + 66'(prod_r[r][1]) + 66'(prod_r[r][2]);
      end
      // Stage 3: floor to the fixed-point grid and add the translation entry.
      for (int r = 0; r < NUM_ROWS; r++) begin
        clip_r[r] <= CW'(sum_r[r] >>> FRAC_BITS) + CW'($signed(row_r[2*r+1][63:32]));
      end
      // Stage 4: visibility test and magnitudes of X and Y.
      meta4_r.vis   <= clip_r[2] >= $signed(CW'(W_MIN));
      meta4_r.neg_x <= clip_r[0][CW-1];
      meta4_r.neg_y <= clip_r[1][CW-1];
      magx_r        <= clip_r[0][CW-1] ? MW'(-clip_r[0]) : MW'(clip_r[0]);
      magy_r        <= clip_r[1][CW-1] ? MW'(-clip_r[1]) : MW'(clip_r[1]);
      w4_r          <= clip_r[2][WW-1:0];
      // Stage 5: half size times magnitude, split into two partial products.
      meta5_r <= meta4_r;
      w5_r    <= w4_r;
      plox_r  <= (HW+ML)'(hx) * (HW+ML)'(magx_r[ML-1:0]);
      ploy_r  <= (HW+ML)'(hy) * (HW+ML)'(magy_r[ML-1:0]);
      phix_r  <= (HW+MW-ML)'(hx) * (HW+MW-ML)'(magx_r[MW-1:ML]);
      phiy_r  <= (HW+MW-ML)'(hy) * (HW+MW-ML)'(magy_r[MW-1:ML]);
      // Stage 6: assemble the dividends.
      meta6_r <= meta5_r;
      w6_r    <= w5_r;
      nx_r    <= (NW'(phix_r) << ML) + NW'(plox_r);
      ny_r    <= (NW'(phiy_r) << ML) + NW'(ploy_r);
    end
  end

  pps_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v6_r),
    .meta_i (meta6_r),
    .nx_i   (nx_r),
    .ny_i   (ny_r),
    .w_i    (w6_r),
    .vld_o  (dv_vld),
    .meta_o (dv_meta),
    .qx_o   (dv_qx),
    .qy_o   (dv_qy),
    .ovfx_o (dv_ovfx),
    .ovfy_o (dv_ovfy)
  );

  always_comb begin
    tx     = ratio(dv_qx, dv_ovfx, dv_meta.neg_x);
    ty     = ratio(dv_qy, dv_ovfy, dv_meta.neg_y);
    resx   = $signed(RW'(hx)) + tx;
    resy   = $signed(RW'(hy)) - ty;
    sx_nxt = dv_meta.vis ? clamp32(resx) : '0;
    sy_nxt = dv_meta.vis ? clamp32(resy) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vis_r <= dv_meta.vis;
      out_x_r   <= sx_nxt;
      out_y_r   <= sy_nxt;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.visible  = out_vis_r;
  assign out_ch.screen_x = out_x_r;
  assign out_ch.screen_y = out_y_r;

endmodule

[rtl/core/pps_checker.sv]
// Port-level checks for the projection pipeline, bound to the top level.
module pps_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_visible,
  input logic [31:0] out_screen_x,
  input logic [31:0] out_screen_y
);

  // A point behind the near limit reports zero coordinates.
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_screen_x == '0 && out_screen_y == '0)
    else $error("hidden point with nonzero coordinates");

  // With the output register empty the block must take a new point.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // The cycle after reset no result is shown.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_screen_x) && $stable(out_screen_y))
    else $error("result changed while stalled");

endmodule

bind perspective_project_to_screen pps_sva u_pps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_visible  (out_ch.visible),
  .out_screen_x (out_ch.screen_x),
  .out_screen_y (out_ch.screen_y)
);

[verif/pps_checker.sv]
// Scoreboard for the projection block: predicts each screen result and compares it.
module pps_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  pps_in_if                                      in_ch,
  pps_out_if                                     out_ch,
  input  logic                                   cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [pps_pkg::CFG_DATA_W-1:0]         cfg_data,
  output int                                     fails,
  output int                                     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  typedef struct {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } screen_pt_t;

  logic [63:0] regs [8];
  screen_pt_t  expected_pts[$];

  // Floor of the three-term dot product in fixed point, plus the row offset.
  function automatic logic signed [63:0] clip_coord(logic [63:0] lo, logic [63:0] hi,
                                                    logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
    logic signed [127:0] c0, c1, c2, v0, v1, v2, acc, ofs;
    c0 = $signed(lo[31:0]);
    c1 = $signed(lo[63:32]);
    c2 = $signed(hi[31:0]);
    ofs = $signed(hi[63:32]);
    v0 = px;
    v1 = py;
    v2 = pz;
    acc = (c0 * v0 + c1 * v1 + c2 * v2) >>> FRAC_BITS;
    return 64'(acc + ofs);
  endfunction

  // Truncated h*v/w with the magnitude capped at 2^40; w is positive.
  function automatic logic signed [63:0] scaled_ratio(logic [63:0] h, logic signed [63:0] v,
                                                      logic signed [63:0] w);
    logic [127:0] mag, q;
    mag = (v < 0) ? 128'(-v) : 128'(v);
    q = (128'(h) * mag) / 128'(w);
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (v < 0) ? -$signed(64'(q)) : $signed(64'(q));
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic screen_pt_t project_point(logic signed [31:0] px,
                                               logic signed [31:0] py,
                                               logic signed [31:0] pz);
    screen_pt_t r;
    logic signed [63:0] cx, cy, cw, hx, hy;
    cx = clip_coord(regs[REG_X_ROW_LO], regs[REG_X_ROW_HI], px, py, pz);
    cy = clip_coord(regs[REG_Y_ROW_LO], regs[REG_Y_ROW_HI], px, py, pz);
    cw = clip_coord(regs[REG_W_ROW_LO], regs[REG_W_ROW_HI], px, py, pz);
    r.visible = 0;
    r.screen_x = 0;
    r.screen_y = 0;
    if (cw >= W_MIN) begin
      hx = 64'(regs[REG_SCR_WIDTH][SIZE_W-1:0]) << (FRAC_BITS - 1);
      hy = 64'(regs[REG_SCR_HEIGHT][SIZE_W-1:0]) << (FRAC_BITS - 1);
      r.visible = 1;
      r.screen_x = sat32(hx + scaled_ratio(hx, cx, cw));
      r.screen_y = sat32(hy - scaled_ratio(hy, cy, cw));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    screen_pt_t e;
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = '0;
      expected_pts.delete();
      fails = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pts.size() == 0) begin
          $error("screen result with no point outstanding");
          fails++;
        end else begin
          e = expected_pts.pop_front();
          if (out_ch.visible !== e.visible) begin
            $error("visible: expected %0d, got %0d", e.visible, out_ch.visible);
            fails++;
          end
          if (out_ch.screen_x !== e.screen_x) begin
            $error("screen_x: expected %0d, got %0d", e.screen_x, out_ch.screen_x);
            fails++;
          end
          if (out_ch.screen_y !== e.screen_y) begin
            $error("screen_y: expected %0d, got %0d", e.screen_y, out_ch.screen_y);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_pts.push_back(project_point(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z));
      if (cfg_we)
        regs[cfg_idx] = (cfg_idx >= REG_SCR_WIDTH) ? (cfg_data & 64'h1FFF) : cfg_data;
    end
    pending = expected_pts.size();
  end

endmodule

[verif/tb.sv]
// Top of the projection testbench: clock, reset, stimulus, flow control and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int LONG_HOLD       = 400;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fails;
  int                    pending;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();

  perspective_project_to_screen i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  pps_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always #6 clk = ~clk;

  // Receiver flow control: random stall modes, plus one long hold-off on request.
  bit hold_req, hold_done;
  int hold_left, mode_left, stall_mode;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
          0: out_ch.ready <= 1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles in which no transfer happens on either channel.
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  int burst_left;

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    if (burst_left == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid <= 1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    // Inputs and ready only change at the rising edge, so the low phase is stable.
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic write_view(logic [63:0] xl, logic [63:0] xh, logic [63:0] yl,
                            logic [63:0] yh, logic [63:0] wl, logic [63:0] wh,
                            logic [12:0] width, logic [12:0] height);
    logic [63:0] vals [8];
    vals = '{xl, xh, yl, yh, wl, wh, 64'(width), 64'(height)};
    in_ch.valid <= 0;
    // The scoreboard count settles after the rising edge, so read it in the low phase.
    do @(negedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_idx <= CFG_IDX_W'(i);
      cfg_data <= (i >= 6 && $urandom_range(0, 1)) ? (vals[i] | 64'hFFFF_E000) : vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_entry(bit wide);
    if (wide) return $urandom();
    return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  function automatic logic [31:0] rand_coord(bit wide);
    if (wide) return $urandom();
    return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
  endfunction

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NMIN = 32'h8000_0000;

  initial begin
    logic [12:0] w_sz, h_sz;
    bit wide_m, wide_p;
    in_ch.valid <= 0;
    in_ch.pos_x <= 0;
    in_ch.pos_y <= 0;
    in_ch.pos_z <= 0;
    cfg_we <= 0;
    cfg_idx <= 0;
    cfg_data <= 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Points with all-zero registers are never visible.
    send_point(ONE, ONE, ONE);
    send_point(PMAX, NMIN, PMAX);

    // Plain view: X = x, Y = y, W = z.
    write_view({32'd0, ONE}, 64'd0, {ONE, 32'd0}, 64'd0, 64'd0, {32'd0, ONE},
               13'd1920, 13'd1080);
    send_point(0, 0, 0);
    send_point(ONE, ONE, ONE);
    send_point(0, 0, 32'd6554);          // W exactly at the visibility threshold
    send_point(0, 0, 32'd6553);          // W just below it
    send_point(ONE, ONE, -ONE);
    send_point(PMAX, NMIN, 32'd6554);    // far off screen, both axes saturate
    send_point(NMIN, PMAX, 32'd6554);
    send_point(PMAX, PMAX, PMAX);
    send_point(NMIN, NMIN, NMIN);
    send_point(-ONE, 32'h0000_8000, 32'h0002_0000);

    // Extreme entries and viewport sizes.
    write_view({PMAX, NMIN}, {PMAX, NMIN}, {NMIN, PMAX}, {NMIN, PMAX},
               {PMAX, PMAX}, {PMAX, PMAX}, 13'd8191, 13'd8191);
    send_point(PMAX, PMAX, PMAX);
    send_point(NMIN, NMIN, NMIN);
    send_point(ONE, 0, 0);
    send_point(0, 0, 0);
    write_view({ONE, ONE}, {32'd0, ONE}, {ONE, NMIN}, {PMAX, ONE},
               {32'd0, 32'd0}, {ONE, 32'd0}, 13'd0, 13'd0);
    send_point(ONE, ONE, ONE);
    send_point(PMAX, NMIN, 0);
    send_point(NMIN, PMAX, ONE);

    for (int phase = 0; phase < 8; phase++) begin
      wide_m = (phase % 4 == 3);
      w_sz = (phase == 2) ? 13'd8191 : (phase == 5) ? 13'd0 : 13'($urandom_range(1, 8191));
      h_sz = (phase == 2) ? 13'd0 : (phase == 5) ? 13'd8191 : 13'($urandom_range(1, 8191));
      write_view({rand_entry(wide_m), rand_entry(wide_m)},
                 {rand_entry(wide_m), rand_entry(wide_m)},
                 {rand_entry(wide_m), rand_entry(wide_m)},
                 {rand_entry(wide_m), rand_entry(wide_m)},
                 {rand_entry(wide_m), rand_entry(wide_m)},
                 {32'($urandom_range(0, 100 << 16)) - 32'(phase[0] << 20),
                  rand_entry(wide_m)},
                 w_sz, h_sz);
      for (int n = 0; n < 115; n++) begin
        if (phase == 2 && n == 40) hold_req = 1;
        wide_p = ($urandom_range(0, 4) == 0);
        send_point(rand_coord(wide_p), rand_coord(wide_p), rand_coord(wide_p));
      end
    end

    in_ch.valid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
rtl/core/pps_pkg.sv
rtl/core/pps_if.sv
rtl/core/pps_div.sv
rtl/core/perspective_project_to_screen.sv
rtl/core/pps_checker.sv
verif/pps_checker.sv
verif/tb.sv
